[design/ntpcal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpcal_pkg
// Shared types, constants and calendar helpers for the NTP seconds to local
// calendar converter.
// ----------------------------------------------------------------------------
package ntpcal_pkg;

    localparam int unsigned DaySec  = 86400;
    localparam int unsigned HourSec = 3600;
    localparam int unsigned MinSec  = 60;

    // configuration register indexes
    localparam logic [1:0] CFG_ZONE   = 2'd0;
    localparam logic [1:0] CFG_DST_EN = 2'd1;
    localparam logic [1:0] CFG_EUROPE = 2'd2;

    typedef struct packed {
        logic capture_in;
        logic load_sec;
        logic sel_loc;
        logic step_year;
        logic step_month;
        logic latch_w1;
        logic step_day;
        logic step_hour;
        logic step_min;
        logic set_dst;
        logic clear_dst;
        logic capture_out;
    } t_cmd;

    typedef struct packed {
        logic std_ok;
        logic dst_en;
        logic loc_ok;
        logic year_more;
        logic month_more;
        logic day_more;
        logic hour_more;
        logic min_more;
    } t_status;

    function automatic logic is_leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // days from 1900-01-01 to 1 January of year y
    function automatic longint days_before(input int y);
        longint d;
        d = 0;
        for (int k = 1900; k < y; k++) begin
            d = d + (is_leap_year(k) ? 366 : 365);
        end
        return d;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] wday_add(input logic [2:0] w, input logic [1:0] inc);
        logic [3:0] s;
        s = {1'b0, w} + {2'b00, inc};
        return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
    endfunction

endpackage
`default_nettype wire

[design/ntp_seconds_to_local_calendar.sv]
// Each request runs the split passes: none when the time is out of range, one
// when DST is off, else two. Each pass steps through the years since BASE_YEAR,
// then the months, days, hours and minutes, one subtraction per step.
// One request at a time: a new request is taken only after the last result is
// loaded into the output register; the shared subtract-and-compare unit serves
// every step. Reset (synchronous, active low) restores the config registers.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntp_seconds_to_local_calendar
// Converts an NTP era-0 seconds count to local calendar date and time with a
// whole-hour zone offset and US or European daylight saving.
// ----------------------------------------------------------------------------
module ntp_seconds_to_local_calendar #(
    parameter int BASE_YEAR = 2014
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // configuration write port
    input  wire               i_cfg_we,
    input  wire  [1:0]        i_cfg_index,
    input  wire  [4:0]        i_cfg_data,
    // request channel
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire  [31:0]       i_ntp_seconds,
    // result channel
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [10:0]       o_year_value,
    output logic [3:0]        o_month_value,
    output logic [4:0]        o_day_of_month,
    output logic [4:0]        o_hour_value,
    output logic [5:0]        o_minute_value,
    output logic [5:0]        o_second_value,
    output logic [2:0]        o_weekday,
    output logic              o_dst_active,
    output logic signed [4:0] o_offset_in_effect,
    output logic              o_out_of_range
);
    import ntpcal_pkg::*;

    // Flow of one request:
    //   capture the seconds plus zone offset (standard local time);
    //   if it lies at or after the base year and DST is enabled, split it
    //   into a calendar by repeated subtraction and apply the DST rule;
    //   then split the final local time again, or flag it out of range.
    // The weekday of the month's first day is held from the month loop so
    // the DST Sundays follow without any table.
    t_cmd    cmd;
    t_status status;

    ntpcal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ntpcal_dp #(
        .BASE_YEAR (BASE_YEAR)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_ntp_seconds      (i_ntp_seconds),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_year_value       (o_year_value),
        .o_month_value      (o_month_value),
        .o_day_of_month     (o_day_of_month),
        .o_hour_value       (o_hour_value),
        .o_minute_value     (o_minute_value),
        .o_second_value     (o_second_value),
        .o_weekday          (o_weekday),
        .o_dst_active       (o_dst_active),
        .o_offset_in_effect (o_offset_in_effect),
        .o_out_of_range     (o_out_of_range)
    );

endmodule
`default_nettype wire

[design/ntpcal_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpcal_ctrl
// Sequencer: runs the split passes, the DST decision and the result handoff.
// ----------------------------------------------------------------------------
module ntpcal_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    input  ntpcal_pkg::t_status   i_status,
    output ntpcal_pkg::t_cmd      o_cmd
);
    import ntpcal_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_CHECK  = 9'b000000010,
        ST_YEAR   = 9'b000000100,
        ST_MONTH  = 9'b000001000,
        ST_DAY    = 9'b000010000,
        ST_HOUR   = 9'b000100000,
        ST_MINUTE = 9'b001000000,
        ST_DECIDE = 9'b010000000,
        ST_FINISH = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_pass  = r_pass;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture_in = 1'b1;
                    n_state        = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // first pass only when the standard time may need DST
                if (i_status.std_ok && i_status.dst_en) begin
                    cmd.load_sec = 1'b1;
                    n_pass       = 1'b0;
                    n_state      = ST_YEAR;
                end else begin
                    cmd.clear_dst = 1'b1;
                    n_state       = ST_DECIDE;
                end
            end
            ST_YEAR: begin
                if (i_status.year_more) cmd.step_year = 1'b1;
                else                    n_state = ST_MONTH;
            end
            ST_MONTH: begin
                if (i_status.month_more) begin
                    cmd.step_month = 1'b1;
                end else begin
                    cmd.latch_w1 = 1'b1;
                    n_state      = ST_DAY;
                end
            end
            ST_DAY: begin
                if (i_status.day_more) cmd.step_day = 1'b1;
                else                   n_state = ST_HOUR;
            end
            ST_HOUR: begin
                if (i_status.hour_more) cmd.step_hour = 1'b1;
                else                    n_state = ST_MINUTE;
            end
            ST_MINUTE: begin
                if (i_status.min_more) begin
                    cmd.step_min = 1'b1;
                end else if (r_pass) begin
                    n_state = ST_FINISH;
                end else begin
                    cmd.set_dst = 1'b1;
                    n_state     = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // DST known: split local time, or flag it out of range
                if (i_status.loc_ok) begin
                    cmd.load_sec = 1'b1;
                    cmd.sel_loc  = 1'b1;
                    n_pass       = 1'b1;
                    n_state      = ST_YEAR;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.capture_out = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            if (cmd.capture_out)  r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_CHECK))
        else $error("accepted request did not start conversion");
    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_out_valid && !i_out_ready) |=> (r_state == ST_FINISH))
        else $error("finish left while output stalled");

endmodule
`default_nettype wire

[design/ntpcal_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntpcal_dp
// Datapath: config registers, offset add, subtractive calendar split, DST test
// and the output register.
// ----------------------------------------------------------------------------
module ntpcal_dp #(
    parameter int BASE_YEAR = 2014
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [4:0]           i_cfg_data,
    input  wire  [31:0]          i_ntp_seconds,
    input  ntpcal_pkg::t_cmd     i_cmd,
    output ntpcal_pkg::t_status  o_status,
    output logic [10:0]          o_year_value,
    output logic [3:0]           o_month_value,
    output logic [4:0]           o_day_of_month,
    output logic [4:0]           o_hour_value,
    output logic [5:0]           o_minute_value,
    output logic [5:0]           o_second_value,
    output logic [2:0]           o_weekday,
    output logic                 o_dst_active,
    output logic signed [4:0]    o_offset_in_effect,
    output logic                 o_out_of_range
);
    import ntpcal_pkg::*;

    localparam longint BaseDays = days_before(BASE_YEAR);
    localparam logic signed [34:0] BaseStart = 35'(BaseDays * 86400);
    localparam logic [2:0]  BaseWday = 3'((BaseDays + 1) % 7);
    localparam logic [1:0]  BaseY4   = 2'(BASE_YEAR % 4);
    localparam logic [6:0]  BaseY100 = 7'(BASE_YEAR % 100);
    localparam logic [8:0]  BaseY400 = 9'(BASE_YEAR % 400);

    logic signed [4:0]  r_zone;
    logic               r_dst_en, r_europe;
    logic signed [34:0] r_std;
    logic               r_dst;
    logic [32:0]        r_sec;
    logic [10:0]        r_year;
    logic [1:0]         r_y4;
    logic [6:0]         r_y100;
    logic [8:0]         r_y400;
    logic [3:0]         r_month;
    logic [4:0]         r_day, r_hour;
    logic [5:0]         r_min;
    logic [2:0]         r_wday, r_w1;

    logic               leap;
    logic [32:0]        year_secs, month_secs;
    logic [4:0]         mlen;
    logic signed [34:0] std_next, loc_t;
    logic [4:0]         fs, ls;
    logic [3:0]         w_late;
    logic               us_on, eu_on;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone   <= -5'sd5;
            r_dst_en <= 1'b1;
            r_europe <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ZONE:   r_zone   <= signed'(i_cfg_data);
                CFG_DST_EN: r_dst_en <= i_cfg_data[0];
                CFG_EUROPE: r_europe <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign std_next = signed'({3'b000, i_ntp_seconds})
                    + 35'(r_zone) * 35'sd3600;
    assign loc_t    = r_std + (r_dst ? 35'sd3600 : 35'sd0);

    assign leap       = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign year_secs  = leap ? 33'd31622400 : 33'd31536000;
    assign mlen       = month_days(r_month, leap);
    assign month_secs = 33'(mlen) * 33'(DaySec);

    // DST Sundays from the weekday of the month's first day
    assign fs     = (r_w1 == 3'd0) ? 5'd1 : 5'(4'd8 - {1'b0, r_w1});
    assign w_late = ({1'b0, r_w1} + 4'd2 >= 4'd7) ? {1'b0, r_w1} - 4'd5
                                                  : {1'b0, r_w1} + 4'd2;
    assign ls     = 5'd31 - {1'b0, w_late};

    always_comb begin
        us_on = 1'b0;
        if (r_month > 4'd3 && r_month < 4'd11) us_on = 1'b1;
        else if (r_month == 4'd3)
            us_on = (r_day > fs + 5'd7) || (r_day == fs + 5'd7 && r_hour >= 5'd2);
        else if (r_month == 4'd11)
            us_on = (r_day < fs) || (r_day == fs && r_hour < 5'd2);
        eu_on = 1'b0;
        if (r_month > 4'd3 && r_month < 4'd10) eu_on = 1'b1;
        else if (r_month == 4'd3)
            eu_on = (r_day > ls) || (r_day == ls && r_hour >= 5'd1);
        else if (r_month == 4'd10)
            eu_on = (r_day < ls) || (r_day == ls && r_hour < 5'd1);
    end

    always_comb begin
        o_status            = '0;
        o_status.std_ok     = (r_std >= BaseStart);
        o_status.dst_en     = r_dst_en;
        o_status.loc_ok     = (loc_t >= BaseStart);
        o_status.year_more  = (r_sec >= year_secs);
        o_status.month_more = (r_month < 4'd12) && (r_sec >= month_secs);
        o_status.day_more   = (r_sec >= 33'(DaySec));
        o_status.hour_more  = (r_sec >= 33'(HourSec));
        o_status.min_more   = (r_sec >= 33'(MinSec));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_in) r_std <= std_next;
        if (i_cmd.clear_dst)    r_dst <= 1'b0;
        else if (i_cmd.set_dst) r_dst <= r_europe ? eu_on : us_on;
        if (i_cmd.latch_w1) r_w1 <= r_wday;

        if (i_cmd.load_sec) begin
            r_sec   <= i_cmd.sel_loc ? 33'(loc_t - BaseStart) : 33'(r_std - BaseStart);
            r_year  <= 11'(BASE_YEAR);
            r_y4    <= BaseY4;
            r_y100  <= BaseY100;
            r_y400  <= BaseY400;
            r_month <= 4'd1;
            r_day   <= 5'd1;
            r_hour  <= 5'd0;
            r_min   <= 6'd0;
            r_wday  <= BaseWday;
        end else if (i_cmd.step_year) begin
            r_sec  <= r_sec - year_secs;
            r_year <= r_year + 11'd1;
            r_y4   <= r_y4 + 2'd1;
            r_y100 <= (r_y100 == 7'd99)  ? 7'd0 : r_y100 + 7'd1;
            r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
            r_wday <= wday_add(r_wday, leap ? 2'd2 : 2'd1);
        end else if (i_cmd.step_month) begin
            r_sec   <= r_sec - month_secs;
            r_month <= r_month + 4'd1;
            r_wday  <= wday_add(r_wday, 2'(mlen - 5'd28));
        end else if (i_cmd.step_day) begin
            r_sec  <= r_sec - 33'(DaySec);
            r_day  <= r_day + 5'd1;
            r_wday <= wday_add(r_wday, 2'd1);
        end else if (i_cmd.step_hour) begin
            r_sec  <= r_sec - 33'(HourSec);
            r_hour <= r_hour + 5'd1;
        end else if (i_cmd.step_min) begin
            r_sec <= r_sec - 33'(MinSec);
            r_min <= r_min + 6'd1;
        end

        if (i_cmd.capture_out) begin
            o_out_of_range     <= !o_status.loc_ok;
            o_dst_active       <= r_dst;
            o_offset_in_effect <= r_zone + (r_dst ? 5'sd1 : 5'sd0);
            if (o_status.loc_ok) begin
                o_year_value   <= r_year;
                o_month_value  <= r_month;
                o_day_of_month <= r_day;
                o_hour_value   <= r_hour;
                o_minute_value <= r_min;
                o_second_value <= r_sec[5:0];
                o_weekday      <= r_wday;
            end else begin
                o_year_value   <= '0;
                o_month_value  <= '0;
                o_day_of_month <= '0;
                o_hour_value   <= '0;
                o_minute_value <= '0;
                o_second_value <= '0;
                o_weekday      <= '0;
            end
        end
    end

endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NTP seconds to local calendar converter. Directed
// requests cover the range ends, the daylight saving edges of both
// rules and offset wrap; random requests follow, each setting in turn.
// ----------------------------------------------------------------------------
module tb_top;
    import ntpcal_pkg::*;

    localparam int BaseYear = 2014;

    // one converted calendar result
    typedef struct packed {
        logic [10:0]       year;
        logic [3:0]        month;
        logic [4:0]        mday;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic [2:0]        wday;
        logic              dst;
        logic signed [4:0] offset;
        logic              oor;
    } t_local;

    // directed row: seconds and, where known by eye, the expected result
    typedef struct {
        logic [31:0] secs;
        logic        typed;
        t_local      res;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [4:0]        i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [31:0]       i_ntp_seconds;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [10:0]       o_year_value;
    logic [3:0]        o_month_value;
    logic [4:0]        o_day_of_month;
    logic [4:0]        o_hour_value;
    logic [5:0]        o_minute_value;
    logic [5:0]        o_second_value;
    logic [2:0]        o_weekday;
    logic              o_dst_active;
    logic signed [4:0] o_offset_in_effect;
    logic              o_out_of_range;

    // shadow of the configuration registers
    logic signed [4:0] zone_hours;
    logic              dst_on;
    logic              eu_rule;

    t_local pending_dates[$];
    int     error_count;
    logic   drive_done;

    ntp_seconds_to_local_calendar #(.BASE_YEAR(BaseYear)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous ceiling on the whole run
    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic bit leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int mlen(input int y, input int m);
        int tab[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap(y)) return 29;
        return tab[m - 1];
    endfunction

    // days from 1900-01-01 to the first of month m of year y
    function automatic longint days_until(input int y, input int m);
        longint d;
        d = 0;
        for (int k = 1900; k < y; k++) d += leap(k) ? 366 : 365;
        for (int k = 1; k < m; k++) d += mlen(y, k);
        return d;
    endfunction

    // 1900-01-01 was a Monday
    function automatic int dow(input longint d);
        return int'((d + 1) % 7);
    endfunction

    // break seconds since 1900 into a calendar; weekday kept in wday
    function automatic t_local break_down(input longint t);
        t_local c;
        longint days;
        int     sod;
        int     y;
        int     m;
        days = t / 86400;
        sod  = int'(t % 86400);
        y    = 1900;
        m    = 1;
        c.wday = 3'(dow(days));
        while (days >= (leap(y) ? 366 : 365)) begin
            days -= leap(y) ? 366 : 365;
            y++;
        end
        while (m < 12 && days >= mlen(y, m)) begin
            days -= mlen(y, m);
            m++;
        end
        c.year   = 11'(y);
        c.month  = 4'(m);
        c.mday   = 5'(days + 1);
        c.hour   = 5'(sod / 3600);
        c.minute = 6'((sod % 3600) / 60);
        c.second = 6'(sod % 60);
        c.dst    = 1'b0;
        c.offset = '0;
        c.oor    = 1'b0;
        return c;
    endfunction

    // summer time test on standard local time
    function automatic bit summer_time(input t_local c, input bit europe);
        int y;
        int s;
        y = int'(c.year);
        if (!europe) begin
            if (c.month > 3 && c.month < 11) return 1;
            if (c.month == 3) begin
                s = 1 + (7 - dow(days_until(y, 3))) % 7 + 7;
                return (c.mday > s) || (c.mday == s && c.hour >= 2);
            end
            if (c.month == 11) begin
                s = 1 + (7 - dow(days_until(y, 11))) % 7;
                return (c.mday < s) || (c.mday == s && c.hour < 2);
            end
            return 0;
        end
        if (c.month > 3 && c.month < 10) return 1;
        if (c.month == 3) begin
            s = 31 - dow(days_until(y, 3) + 30);
            return (c.mday > s) || (c.mday == s && c.hour >= 1);
        end
        if (c.month == 10) begin
            s = 31 - dow(days_until(y, 10) + 30);
            return (c.mday < s) || (c.mday == s && c.hour < 1);
        end
        return 0;
    endfunction

    function automatic t_local local_date(input logic [31:0] secs);
        longint start_secs;
        longint std_t;
        bit     summer;
        t_local c;
        start_secs = days_until(BaseYear, 1) * 86400;
        std_t      = longint'(secs) + longint'(zone_hours) * 3600;
        summer     = 0;
        if (std_t >= start_secs && dst_on)
            summer = summer_time(break_down(std_t), eu_rule);
        if (std_t + (summer ? 3600 : 0) < start_secs) begin
            c = '{default: '0};
            c.offset = zone_hours;
            c.oor    = 1'b1;
            return c;
        end
        c = break_down(std_t + (summer ? 3600 : 0));
        c.dst    = summer;
        c.offset = zone_hours + 5'(summer);
        return c;
    endfunction

    // seconds count of a UTC date and time
    function automatic logic [31:0] utc_secs(input int y, input int m, input int d,
                                             input int h, input int mi);
        return 32'((days_until(y, m) + d - 1) * 86400 + h * 3600 + mi * 60);
    endfunction

    // ---------------------------------------------------------------- checks

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_local w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_dates.size() == 0) begin
                report("unrequested result", 1, 0);
            end else begin
                w = pending_dates.pop_front();
                if (o_year_value !== w.year)    report("year", o_year_value, w.year);
                if (o_month_value !== w.month)  report("month", o_month_value, w.month);
                if (o_day_of_month !== w.mday)  report("day", o_day_of_month, w.mday);
                if (o_hour_value !== w.hour)    report("hour", o_hour_value, w.hour);
                if (o_minute_value !== w.minute) report("minute", o_minute_value, w.minute);
                if (o_second_value !== w.second) report("second", o_second_value, w.second);
                if (o_weekday !== w.wday)       report("weekday", o_weekday, w.wday);
                if (o_dst_active !== w.dst)     report("dst", o_dst_active, w.dst);
                if (o_offset_in_effect !== w.offset)
                    report("offset", o_offset_in_effect, w.offset);
                if (o_out_of_range !== w.oor)   report("range flag", o_out_of_range, w.oor);
            end
        end
    end

    // result side: random back-pressure, mostly short, some long, some none
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                              : $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- drive

    task automatic cfg_write(input logic [1:0] idx, input logic [4:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_ZONE:   zone_hours = val;
            CFG_DST_EN: dst_on     = val[0];
            CFG_EUROPE: eu_rule    = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // queue its expected calendar, then hold the request until taken;
    // valid stays up after acceptance so the next request can follow at once
    task automatic send(input logic [31:0] secs, input bit gaps);
        if (gaps && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 150)
                                                 : $urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_ntp_seconds <= secs;
        pending_dates.push_back(local_date(secs));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // drop the request line and let the block fall idle before a register write
    task automatic drain;
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_dates.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    // most requests land in the block's calendar range, some anywhere
    function automatic logic [31:0] random_secs();
        int y;
        int m;
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return utc_secs(2014, 1, 1, 0, 0) + $urandom_range(0, 86400) - 43200;
            2, 3: begin
                y = $urandom_range(2014, 2035);
                m = ($urandom_range(0, 1) == 0) ? 3 : ($urandom_range(0, 1) ? 10 : 11);
                return utc_secs(y, m, $urandom_range(1, 31 - (m == 11)),
                                $urandom_range(0, 23), $urandom_range(0, 59))
                       + $urandom_range(0, 59);
            end
            default: return utc_secs(2014, 1, 1, 0, 0) + $urandom_range(0, 725000000);
        endcase
    endfunction

    initial begin
        t_row   rows[$];
        t_row   r;
        logic [4:0] zones[6] = '{5'd27, 5'd0, 5'sd14, -5'sd12, 5'd15, 5'd16};
        int     timer;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_ntp_seconds = '0;
        zone_hours    = -5'sd5;
        dst_on        = 1'b1;
        eu_rule       = 1'b0;
        error_count   = 0;
        drive_done    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under the reset setting (UTC-5, US rule)
        r = '{secs: 32'd0, typed: 1, res: '{default: '0}};
        r.res.offset = -5'sd5;
        r.res.oor    = 1'b1;
        rows.push_back(r);
        r.secs = utc_secs(2014, 1, 1, 4, 59);
        rows.push_back(r);
        // first local second of the base year
        r.secs = utc_secs(2014, 1, 1, 5, 0);
        r.res  = '{11'd2014, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd3, 1'b0, -5'sd5, 1'b0};
        rows.push_back(r);
        // US spring forward 2014-03-09 and fall back 2014-11-02
        r.typed = 0;
        r.secs = utc_secs(2014, 3, 9, 6, 59);  rows.push_back(r);
        r.secs = utc_secs(2014, 3, 9, 7, 0);   rows.push_back(r);
        r.secs = utc_secs(2014, 11, 2, 6, 59); rows.push_back(r);
        r.secs = utc_secs(2014, 11, 2, 7, 0);  rows.push_back(r);
        r.secs = utc_secs(2024, 2, 29, 12, 0); rows.push_back(r);
        r.secs = utc_secs(2035, 12, 31, 23, 59); rows.push_back(r);
        r.secs = 32'hFFFF_FFFF;                rows.push_back(r);
        r.secs = 32'h5555_5555;                rows.push_back(r);
        r.secs = 32'hAAAA_AAAA;                rows.push_back(r);
        foreach (rows[i]) begin
            if (rows[i].typed && local_date(rows[i].secs) != rows[i].res)
                report("directed row", i, -1);
            send(rows[i].secs, 0);
        end
        drain();

        // European edges at UTC+1
        cfg_write(CFG_EUROPE, 5'd1);
        cfg_write(CFG_ZONE, 5'd1);
        send(utc_secs(2015, 3, 29, 0, 59), 0);
        send(utc_secs(2015, 3, 29, 1, 0), 0);
        send(utc_secs(2015, 10, 25, 0, 59), 0);
        send(utc_secs(2015, 10, 25, 1, 0), 0);
        drain();

        // wrap of the summed offset, and an ignored index
        cfg_write(CFG_ZONE, 5'd15);
        cfg_write(2'd3, 5'd0);
        send(utc_secs(2020, 7, 1, 0, 0), 0);
        drain();

        // random phases across zone, rule and enable settings
        for (int p = 0; p < 12; p++) begin
            cfg_write(CFG_ZONE, (p < 6) ? zones[p] : 5'($urandom()));
            cfg_write(CFG_DST_EN, 5'(p % 4 != 3));
            cfg_write(CFG_EUROPE, 5'(p % 2));
            for (int n = 0; n < 108; n++) begin
                send(random_secs(), 1);
                // hold off once until everything is back
                if (p == 5 && n == 50) begin
                    i_in_valid <= 1'b0;
                    timer = 0;
                    while (pending_dates.size() != 0 && timer < 200000) begin
                        @(posedge i_clk);
                        timer++;
                    end
                end
            end
            drain();
        end
        drive_done = 1'b1;
    end

    initial begin
        wait (drive_done);
        if (error_count == 0 && pending_dates.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/ntpcal_pkg.sv
design/ntpcal_ctrl.sv
design/ntpcal_dp.sv
design/ntp_seconds_to_local_calendar.sv
test/tb_top.sv
